// File: hw/rtl/lsmpq_pkg.sv
// Shared types and codes for the linear-scan max priority queue.
package lsmpq_pkg;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned KEY_W    = 16;
	localparam int unsigned TAG_W    = 16;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCC_W    = 5;
	localparam int unsigned CAP_W    = 5;
	localparam int unsigned PADDR_W  = 3;
	localparam int unsigned PDATA_W  = 32;

	localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// register index lives in paddr[2]; paddr[1:0] is the byte offset
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [KEY_W-1:0]    out_key;
		logic [TAG_W-1:0]    out_tag;
		logic [OCC_W-1:0]    occupancy;
	} rsp_t;

endpackage

// File: hw/rtl/linear_scan_max_priority_queue.sv
// Max priority queue kept as an unsorted array, scanned and compacted by one sequencer.
//
//   channel  direction  handshake                        payload
//   req      in         req_valid / req_stall            req_data  (operation, key, tag)
//   rsp      out        rsp_valid / rsp_stall            rsp_data  (status, out_key, out_tag,
//                                                                   occupancy)
//   cfg      in         psel / penable / pwrite / pready paddr, pwdata, prdata
//
// Enqueue, full, empty and unknown requests go from idle straight to done; peek scans the
// entries, dequeue scans and then moves entries down. The result goes valid in the same
// cycle that the next request can be taken. One comparator walks the entry memory one read
// a cycle, then the same read port walks the entries after the maximum to move them down.
// req_stall is high while a request is in flight; the result register lets the next
// request in while rsp_stall holds the previous result. Reset empties the queue and sets
// the capacity to 16; entry memory is not cleared.
module linear_scan_max_priority_queue #(
	parameter int unsigned DEPTH     = 16,
	parameter int unsigned KEY_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  lsmpq_pkg::req_t                   req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output lsmpq_pkg::rsp_t                   rsp_data,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lsmpq_pkg::PADDR_W-1:0]     paddr,
	input  logic [lsmpq_pkg::PDATA_W-1:0]     pwdata,
	output logic [lsmpq_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);
	import lsmpq_pkg::*;

	localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int unsigned ENTRY_W = KEY_WIDTH + TAG_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CAP_W-1:0]      cap_q;
	logic                  deq_q;
	logic [STATUS_W-1:0]   status_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  rd_vld_q;
	logic [ADDR_W-1:0]     rd_idx_q;
	logic [KEY_WIDTH-1:0]  best_key_q;
	logic [TAG_W-1:0]      best_tag_q;
	logic [ADDR_W-1:0]     best_idx_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic [ENTRY_W-1:0]    mem [DEPTH];
	logic [ENTRY_W-1:0]    mem_rdata_q;
	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [ENTRY_W-1:0]    mem_wdata;
	logic [ADDR_W-1:0]     mem_raddr;

	logic                  req_acc;
	logic                  cfg_wr;
	logic                  full;
	logic                  issue;
	logic [KEY_WIDTH-1:0]  rd_key;
	logic [TAG_W-1:0]      rd_tag;
	logic                  take_best;
	logic                  rsp_free;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_q) : '0;

	assign full = (CMP_W'(count_q) >= CMP_W'(cap_q)) || (CMP_W'(count_q) >= CMP_W'(DEPTH));

	assign issue     = (idx_q < count_q);
	assign mem_raddr = idx_q[ADDR_W-1:0];
	assign rd_key    = mem_rdata_q[KEY_WIDTH-1:0];
	assign rd_tag    = mem_rdata_q[ENTRY_W-1:KEY_WIDTH];
	assign take_best = rd_vld_q && ((rd_idx_q == '0) || (rd_key > best_key_q));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[ADDR_W-1:0];
		mem_wdata = {req_data.tag, KEY_WIDTH'(req_data.key)};
		if (state_q == S_IDLE) begin
			mem_we = req_acc && (req_data.operation == OP_ENQUEUE) && !full;
		end else if (state_q == S_SHIFT) begin
			mem_we    = rd_vld_q;
			mem_waddr = rd_idx_q - ADDR_W'(1);
			mem_wdata = mem_rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					deq_q      <= (req_data.operation == OP_DEQUEUE);
					best_key_q <= '0;
					best_tag_q <= '0;
					best_idx_q <= '0;
					idx_q      <= '0;
					rd_idx_q   <= '0;
				end
			end
			S_SCAN: begin
				rd_idx_q <= idx_q[ADDR_W-1:0];
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (take_best) begin
					best_key_q <= rd_key;
					best_tag_q <= rd_tag;
					best_idx_q <= rd_idx_q;
				end
				if (!issue && !rd_vld_q) begin
					idx_q <= CNT_W'(best_idx_q) + CNT_W'(1);
				end
			end
			S_SHIFT: begin
				rd_idx_q <= idx_q[ADDR_W-1:0];
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_DONE: begin
				if (rsp_free) begin
					rsp_q.status    <= status_q;
					rsp_q.out_key   <= KEY_W'(best_key_q);
					rsp_q.out_tag   <= best_tag_q;
					rsp_q.occupancy <= OCC_W'(count_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			status_q    <= ST_OK;
			rd_vld_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					rd_vld_q <= 1'b0;
					if (req_acc) begin
						status_q <= ST_OK;
						state_q  <= S_DONE;
						if (req_data.operation == OP_ENQUEUE) begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if ((req_data.operation == OP_DEQUEUE) ||
							(req_data.operation == OP_PEEK)) begin
							if (count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					rd_vld_q <= issue;
					if (!issue && !rd_vld_q) begin
						state_q <= deq_q ? S_SHIFT : S_DONE;
					end
				end
				S_SHIFT: begin
					rd_vld_q <= issue;
					if (!issue && !rd_vld_q) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
